/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CHECK_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check an implication on every rising clock edge outside reset
`define CHECK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

/* rtl/vmrr_pkg.sv */
package vmrr_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int AW = $clog2(MEM_BYTES);

	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] MODE_IMM = 2'd0;
	localparam logic [1:0] MODE_DIR = 2'd1;
	localparam logic [1:0] MODE_IND = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	localparam logic [3:0] LEN_IMM_BASE = 4'd3;
	localparam logic [3:0] LEN_MEM = 4'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] mode;
		logic [1:0] size;
		logic [15:0] dest_address;
		logic [63:0] operand_two;
		logic [7:0] load_byte;
	} in_t;

	typedef struct packed {
		logic [3:0] instruction_length;
		logic [63:0] result_value;
		logic [7:0] read_byte;
		logic bad_mode;
	} out_t;

	typedef enum logic [2:0] {
		JOB_ROT_IMM = 3'd0,
		JOB_ROT_DIR = 3'd1,
		JOB_ROT_IND = 3'd2,
		JOB_BAD = 3'd3,
		JOB_LOAD = 3'd4,
		JOB_READ = 3'd5,
		JOB_NOP = 3'd6
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [1:0] size;
		logic [15:0] dest;
		logic [63:0] op2;
		logic [7:0] load_byte;
	} job_t;

	typedef struct packed {
		logic busy;
		logic ram_we;
	} back_stat_t;

	// Index of the last byte of an operand of the given size
	function automatic logic [2:0] last_byte(input logic [1:0] size);
		logic [2:0] r;
		case (size)
			2'd0: r = 3'd0;
			2'd1: r = 3'd1;
			2'd2: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

/* rtl/vmrr_ram.sv */
module vmrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one word, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

/* rtl/vmrr_front.sv */
module vmrr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input vmrr_pkg::in_t in_data,
	output logic job_valid,
	output vmrr_pkg::job_t job,
	input logic job_pop
);
	import vmrr_pkg::*;

	job_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	job_t cls;
	logic push;

	// Classify the incoming transfer
	always_comb begin
		cls.size = in_data.size;
		cls.dest = in_data.dest_address;
		cls.op2 = in_data.operand_two;
		cls.load_byte = in_data.load_byte;
		case (in_data.command)
			CMD_EXEC: begin
				case (in_data.mode)
					MODE_IMM: cls.kind = JOB_ROT_IMM;
					MODE_DIR: cls.kind = JOB_ROT_DIR;
					MODE_IND: cls.kind = JOB_ROT_IND;
					default: cls.kind = JOB_BAD;
				endcase
			end
			CMD_LOAD: cls.kind = JOB_LOAD;
			CMD_READ: cls.kind = JOB_READ;
			default: cls.kind = JOB_NOP;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign job_valid = (count_q != 2'd0);
	assign job = entry_q[rd_ptr_q];

	// Store classified jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !job_pop) begin
				count_q <= count_q + 2'd1;
			end else if (job_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

/* rtl/vmrr_back.sv */
module vmrr_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input vmrr_pkg::job_t job,
	output logic job_pop,
	output logic ram_we,
	output logic [vmrr_pkg::AW-1:0] ram_addr,
	output logic [7:0] ram_wdata,
	input logic [7:0] ram_rdata,
	output logic out_valid,
	input logic out_stall,
	output vmrr_pkg::out_t out_data,
	output vmrr_pkg::back_stat_t stat
);
	import vmrr_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PTR = 9'b000000010,
		ST_PWAIT = 9'b000000100,
		ST_SRC = 9'b000001000,
		ST_DST = 9'b000010000,
		ST_DWAIT = 9'b000100000,
		ST_ROT = 9'b001000000,
		ST_WR = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		TGT_PTR = 2'd0,
		TGT_SRC = 2'd1,
		TGT_DST = 2'd2
	} tgt_t;

	state_t state_q;
	job_t job_q;
	logic [2:0] cnt_q;
	logic [2:0] last_q;
	logic pend_q;
	tgt_t pend_tgt_q;
	logic [2:0] pend_idx_q;
	logic [15:0] ptr_q;
	logic [63:0] src_q;
	logic [63:0] dst_q;
	logic [63:0] res_q;
	logic out_valid_q;
	out_t out_q;

	logic issue_rd;
	logic last_hit;
	logic out_free;
	logic [AW-1:0] base;
	logic [63:0] rot;
	logic [5:0] c;
	logic [15:0] t16;
	logic [31:0] t32;
	logic [63:0] t64;
	logic [127:0] t128;
	out_t res_out;

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign issue_rd = (state_q == ST_PTR) || (state_q == ST_SRC) || (state_q == ST_DST);
	assign last_hit = (cnt_q == last_q);
	assign out_free = !out_valid_q || !out_stall;

	// Select the base address of the current access
	always_comb begin
		case (state_q)
			ST_PTR: base = job_q.op2[AW-1:0];
			ST_SRC: base = (job_q.kind == JOB_ROT_IND) ? ptr_q[AW-1:0] : job_q.op2[AW-1:0];
			default: base = job_q.dest[AW-1:0];
		endcase
	end

	// Drive the memory port
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = res_q[{cnt_q, 3'b000} +: 8];
		ram_addr = AW'(base + AW'(cnt_q));
		if (job_pop && (job.kind == JOB_LOAD)) begin
			ram_we = 1'b1;
			ram_addr = job.dest[AW-1:0];
			ram_wdata = job.load_byte;
		end else if (state_q == ST_WR) begin
			ram_we = 1'b1;
		end
	end

	// Rotate the destination by the count modulo the width
	always_comb begin
		c = src_q[5:0];
		t16 = {dst_q[7:0], dst_q[7:0]} >> c[2:0];
		t32 = {dst_q[15:0], dst_q[15:0]} >> c[3:0];
		t64 = {dst_q[31:0], dst_q[31:0]} >> c[4:0];
		t128 = {dst_q, dst_q} >> c;
		case (job_q.size)
			2'd0: rot = {56'd0, t16[7:0]};
			2'd1: rot = {48'd0, t32[15:0]};
			2'd2: rot = {32'd0, t64[31:0]};
			default: rot = t128[63:0];
		endcase
	end

	// Build the result item
	always_comb begin
		res_out.instruction_length = 4'd0;
		res_out.result_value = 64'd0;
		res_out.read_byte = 8'd0;
		res_out.bad_mode = 1'b0;
		case (job_q.kind)
			JOB_ROT_IMM: begin
				res_out.instruction_length = LEN_IMM_BASE + (4'd1 << job_q.size);
				res_out.result_value = res_q;
			end
			JOB_ROT_DIR, JOB_ROT_IND: begin
				res_out.instruction_length = LEN_MEM;
				res_out.result_value = res_q;
			end
			JOB_READ: res_out.read_byte = dst_q[7:0];
			JOB_BAD: res_out.bad_mode = 1'b1;
			default: res_out.bad_mode = 1'b0;
		endcase
	end

	// Sequence the job's memory accesses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 3'd0;
			last_q <= 3'd0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= issue_rd;
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 3'd0;
					if (job_valid) begin
						case (job.kind)
							JOB_ROT_IMM: begin
								last_q <= last_byte(job.size);
								state_q <= ST_DST;
							end
							JOB_ROT_DIR: begin
								last_q <= last_byte(job.size);
								state_q <= ST_SRC;
							end
							JOB_ROT_IND: begin
								last_q <= 3'd1;
								state_q <= ST_PTR;
							end
							JOB_READ: begin
								last_q <= 3'd0;
								state_q <= ST_DST;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_PTR: begin
					cnt_q <= last_hit ? 3'd0 : cnt_q + 3'd1;
					if (last_hit) begin
						state_q <= ST_PWAIT;
					end
				end
				ST_PWAIT: begin
					last_q <= last_byte(job_q.size);
					state_q <= ST_SRC;
				end
				ST_SRC: begin
					cnt_q <= last_hit ? 3'd0 : cnt_q + 3'd1;
					if (last_hit) begin
						state_q <= ST_DST;
					end
				end
				ST_DST: begin
					cnt_q <= last_hit ? 3'd0 : cnt_q + 3'd1;
					if (last_hit) begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: state_q <= (job_q.kind == JOB_READ) ? ST_OUT : ST_ROT;
				ST_ROT: state_q <= ST_WR;
				ST_WR: begin
					cnt_q <= last_hit ? 3'd0 : cnt_q + 3'd1;
					if (last_hit) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the job and capture operand bytes
	always_ff @(posedge clk) begin
		if (issue_rd) begin
			pend_idx_q <= cnt_q;
			case (state_q)
				ST_PTR: pend_tgt_q <= TGT_PTR;
				ST_SRC: pend_tgt_q <= TGT_SRC;
				default: pend_tgt_q <= TGT_DST;
			endcase
		end
		if (job_pop) begin
			job_q <= job;
			src_q <= (job.kind == JOB_ROT_IMM) ? job.op2 : 64'd0;
			dst_q <= 64'd0;
		end else if (pend_q) begin
			case (pend_tgt_q)
				TGT_PTR: ptr_q[{pend_idx_q[0], 3'b000} +: 8] <= ram_rdata;
				TGT_SRC: src_q[{pend_idx_q, 3'b000} +: 8] <= ram_rdata;
				default: dst_q[{pend_idx_q, 3'b000} +: 8] <= ram_rdata;
			endcase
		end
		if (state_q == ST_ROT) begin
			res_q <= rot;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q <= res_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.ram_we = ram_we;
endmodule

/* rtl/vm_rotate_right_exec.sv */
// Rotate-right executor over a byte-wide little-endian data memory. Items pass a two-entry
// queue to a sequencer that owns the single memory port, one byte per cycle, and a result is
// held while the result side stalls. The operand size n is 1, 2, 4 or 8 bytes; direct and
// indirect mode read n source bytes from memory, immediate mode reads none, and indirect
// mode first reads a two-byte pointer. Memory bytes must be loaded before they are read.
// A result waits in an output register while the next item is already accepted into the
// queue.
`include "assert_macros.svh"

module vm_rotate_right_exec (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input vmrr_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output vmrr_pkg::out_t out_data
);
	import vmrr_pkg::*;

	logic job_valid;
	job_t job;
	logic job_pop;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata;
	logic [7:0] ram_rdata;
	back_stat_t stat;

	vmrr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.job_valid(job_valid),
		.job(job),
		.job_pop(job_pop)
	);

	vmrr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job),
		.job_pop(job_pop),
		.ram_we(ram_we),
		.ram_addr(ram_addr),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.stat(stat)
	);

	vmrr_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	`CHECK_IMPL(a_full_has_job, clk, arst_n, in_stall, job_valid)
	`CHECK_IMPL(a_pop_has_job, clk, arst_n, job_pop, job_valid && !stat.busy)
	`CHECK_PROP(a_result_after_work, clk, arst_n, $rose(out_valid) |-> $past(stat.busy))
endmodule
